// ----- design/dphd_pkg.sv -----
package dphd_pkg;

  localparam int SAMPLE_W = 10;
  localparam int CFG_W    = 8;
  localparam int VEL_W    = 7;
  localparam int QUIET_W  = 8;

  // register indexes on the configuration port
  localparam logic [1:0] REG_TRIGGER_LEVEL     = 2'd0;
  localparam logic [1:0] REG_FULL_SCALE_TENTHS = 2'd1;
  localparam logic [1:0] REG_MASK_MS           = 2'd2;

  localparam logic [VEL_W-1:0] VEL_MIN = 7'd1;
  localparam logic [VEL_W-1:0] VEL_MAX = 7'd127;

  typedef struct packed {
    logic [CFG_W-1:0] trigger_level;
    logic [CFG_W-1:0] full_scale_tenths;
    logic [CFG_W-1:0] mask_ms;
  } cfg_t;

  // a finished scan waiting for its velocity
  typedef struct packed {
    logic                zone;
    logic [SAMPLE_W-1:0] peak;
  } hit_t;

  typedef enum logic [3:0] {
    B_IDLE  = 4'b0001,
    B_CHECK = 4'b0010,
    B_DIV   = 4'b0100,
    B_OUT   = 4'b1000
  } back_state_t;

endpackage

// ----- design/dual_piezo_hit_detector_core.sv -----
// drum trigger with retrigger mask, head and rim piezo inputs
//
// input channel (in_valid / in_ready): one transaction per adc sample pair,
// head_sample and rim_sample plus ms_tick marking a millisecond boundary
// output channel (out_valid / out_ready): one transaction per detected
// strike, zone (0 head, 1 rim) and velocity in 1..127
// configuration: apb write of trigger_level at 0x0, full_scale_tenths at
// 0x4, mask_ms at 0x8; reads return the register; pready is always high
//
// the front end takes one sample per cycle while the queue has room, and tracks
// the quiet count and the peak scan; a finished scan goes into a two-entry queue
// the back end turns a queued peak into a velocity with a restoring divider
// of one quotient bit per cycle: it pops and decodes a hit, range-checks it
// (a zero span or an out-of-range peak skips the division), then divides,
// with the output held until taken
// in_ready drops only while the queue is full (three strikes pending: one in
// the back end, two queued); reset restores the register defaults, empties
// the queue and clears the quiet count, so strikes right after reset are
// masked
module dual_piezo_hit_detector_core import dphd_pkg::*; #(
  parameter int SCAN_SAMPLES = 5
) (
  input  logic                clk,
  input  logic                rst,
  // sample channel
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [SAMPLE_W-1:0] head_sample,
  input  logic [SAMPLE_W-1:0] rim_sample,
  input  logic                ms_tick,
  // strike channel
  output logic                out_valid,
  input  logic                out_ready,
  output logic                zone,
  output logic [VEL_W-1:0]    velocity,
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  cfg_t       cfg;
  logic       cfg_wr;
  logic [1:0] reg_idx;

  // front/queue/back handshake
  logic take;
  logic push, q_full, q_avail, q_pop;
  hit_t push_data, q_data;

  // register file
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.trigger_level     <= 8'd20;
      cfg.full_scale_tenths <= 8'd80;
      cfg.mask_ms           <= 8'd10;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_TRIGGER_LEVEL:     cfg.trigger_level     <= pwdata[CFG_W-1:0];
        REG_FULL_SCALE_TENTHS: cfg.full_scale_tenths <= pwdata[CFG_W-1:0];
        REG_MASK_MS:           cfg.mask_ms           <= pwdata[CFG_W-1:0];
        default:               ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_TRIGGER_LEVEL:     prdata = {24'b0, cfg.trigger_level};
      REG_FULL_SCALE_TENTHS: prdata = {24'b0, cfg.full_scale_tenths};
      REG_MASK_MS:           prdata = {24'b0, cfg.mask_ms};
      default:               prdata = '0;
    endcase
  end

  // samples flow while there is room for a finished scan
  assign in_ready = !q_full;
  assign take     = in_valid && in_ready;

  dphd_front #(
    .SCAN_SAMPLES(SCAN_SAMPLES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .take       (take),
    .head_sample(head_sample),
    .rim_sample (rim_sample),
    .ms_tick    (ms_tick),
    .push       (push),
    .push_data  (push_data)
  );

  dphd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_data),
    .full     (q_full),
    .pop      (q_pop),
    .avail    (q_avail),
    .pop_data (q_data)
  );

  dphd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .hit_avail(q_avail),
    .hit      (q_data),
    .hit_pop  (q_pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .zone     (zone),
    .velocity (velocity)
  );

endmodule

// ----- design/dphd_front.sv -----
module dphd_front import dphd_pkg::*; #(
  parameter int SCAN_SAMPLES = 5
) (
  input  logic                clk,
  input  logic                rst,
  input  cfg_t                cfg,
  input  logic                take,
  input  logic [SAMPLE_W-1:0] head_sample,
  input  logic [SAMPLE_W-1:0] rim_sample,
  input  logic                ms_tick,
  output logic                push,
  output hit_t                push_data
);

  localparam int SCAN_W = $clog2(SCAN_SAMPLES + 1);
  localparam logic [SCAN_W-1:0] SCAN_LOAD = SCAN_W'(SCAN_SAMPLES);

  logic                scanning, scanning_next;
  logic [SCAN_W-1:0]   scan_left, scan_left_next;
  logic [SAMPLE_W-1:0] head_peak, head_peak_next;
  logic [SAMPLE_W-1:0] rim_peak, rim_peak_next;
  logic [QUIET_W-1:0]  quiet_ms, quiet_ms_next;
  logic [QUIET_W-1:0]  quiet_ticked;

  always_comb begin
    quiet_ticked = quiet_ms;
    if (ms_tick && quiet_ms != '1) begin
      quiet_ticked = quiet_ms + 1'b1;
    end
    scanning_next  = scanning;
    scan_left_next = scan_left;
    head_peak_next = head_peak;
    rim_peak_next  = rim_peak;
    quiet_ms_next  = quiet_ticked;
    push           = 1'b0;
    if (scanning) begin
      if (head_sample > head_peak) head_peak_next = head_sample;
      if (rim_sample > rim_peak) rim_peak_next = rim_sample;
      scan_left_next = scan_left - 1'b1;
      if (scan_left_next == '0) begin
        push          = take;
        scanning_next = 1'b0;
        quiet_ms_next = '0;
      end
    end else if (head_sample > {2'b00, cfg.trigger_level}) begin
      if (quiet_ticked < cfg.mask_ms) begin
        quiet_ms_next = '0;
      end else begin
        scanning_next  = 1'b1;
        scan_left_next = SCAN_LOAD;
        head_peak_next = '0;
        rim_peak_next  = '0;
      end
    end
    // tie goes to the head
    push_data.zone = (rim_peak_next > head_peak_next);
    push_data.peak = push_data.zone ? rim_peak_next : head_peak_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scanning  <= 1'b0;
      scan_left <= '0;
      head_peak <= '0;
      rim_peak  <= '0;
      quiet_ms  <= '0;
    end else if (take) begin
      scanning  <= scanning_next;
      scan_left <= scan_left_next;
      head_peak <= head_peak_next;
      rim_peak  <= rim_peak_next;
      quiet_ms  <= quiet_ms_next;
    end
  end

endmodule

// ----- design/dphd_queue.sv -----
module dphd_queue import dphd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  hit_t push_data,
  output logic full,
  input  logic pop,
  output logic avail,
  output hit_t pop_data
);

  hit_t       entry [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full     = (count == 2'd2);
  assign avail    = (count != 2'd0);
  assign pop_data = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- design/dphd_back.sv -----
module dphd_back import dphd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  cfg_t             cfg,
  input  logic             hit_avail,
  input  hit_t             hit,
  output logic             hit_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             zone,
  output logic [VEL_W-1:0] velocity
);

  back_state_t state;

  logic [16:0]      num_mag;
  logic [11:0]      span_mag;
  logic             num_neg, span_neg, span_zero;
  logic [18:0]      rem;
  logic [VEL_W-1:0] quot;
  logic [2:0]       bit_idx;

  // decode of the popped hit
  logic signed [10:0] diff;
  logic [9:0]         diff_mag;
  logic [11:0]        fs_x10;
  logic signed [12:0] span;
  logic [18:0]        cap;
  logic [18:0]        trial;
  logic               trial_ok;
  logic [VEL_W-1:0]   quot_next;

  always_comb begin
    diff     = $signed({1'b0, hit.peak}) - $signed({3'b000, cfg.trigger_level});
    diff_mag = diff[10] ? 10'(-diff) : diff[9:0];
    fs_x10   = {1'b0, cfg.full_scale_tenths, 3'b000} + {3'b000, cfg.full_scale_tenths, 1'b0};
    span     = $signed({1'b0, fs_x10}) - $signed({5'b00000, cfg.trigger_level});
    cap      = {span_mag, 7'b0} - {6'b0, span_mag, 1'b0};
    trial    = {7'b0, span_mag} << bit_idx;
    trial_ok = (rem >= trial);
    quot_next = quot;
    quot_next[bit_idx] = trial_ok;
  end

  assign hit_pop   = (state == B_IDLE) && hit_avail;
  assign out_valid = (state == B_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      unique case (state)
        B_IDLE: begin
          if (hit_avail) state <= B_CHECK;
        end
        B_CHECK: begin
          if (span_zero || num_mag == '0 || num_neg != span_neg
              || {2'b00, num_mag} >= cap) begin
            state <= B_OUT;
          end else begin
            state <= B_DIV;
          end
        end
        B_DIV: begin
          if (bit_idx == 3'd0) state <= B_OUT;
        end
        B_OUT: begin
          if (out_ready) state <= B_IDLE;
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      B_IDLE: begin
        zone      <= hit.zone;
        num_neg   <= diff[10];
        num_mag   <= {diff_mag, 7'b0} - {6'b0, diff_mag, 1'b0};
        span_neg  <= span[12];
        span_zero <= (span == '0);
        span_mag  <= span[12] ? 12'(-span) : span[11:0];
      end
      B_CHECK: begin
        rem     <= {2'b00, num_mag};
        quot    <= '0;
        bit_idx <= 3'd6;
        if (span_zero) begin
          velocity <= VEL_MAX;
        end else if (num_mag == '0 || num_neg != span_neg) begin
          velocity <= VEL_MIN;
        end else if ({2'b00, num_mag} >= cap) begin
          velocity <= VEL_MAX;
        end
      end
      B_DIV: begin
        if (trial_ok) rem <= rem - trial;
        quot    <= quot_next;
        bit_idx <= bit_idx - 3'd1;
        if (bit_idx == 3'd0) velocity <= quot_next + VEL_MIN;
      end
      B_OUT: begin
        velocity <= velocity;
      end
      default: begin
        velocity <= velocity;
      end
    endcase
  end

endmodule

// ----- design/dphd_checker.sv -----
module dphd_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        zone,
  input logic [6:0]  velocity,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [3:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready
);

  // a stalled strike stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("strike dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(zone) && $stable(velocity))
    else $error("strike changed while stalled");

  // an offered velocity is never zero
  a_vel_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> velocity != 7'd0)
    else $error("velocity out of range");

  // a written threshold reads back on the next cycle
  a_readback: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && pready && paddr == 4'h0 ##1 paddr == 4'h0
    |-> prdata[7:0] == $past(pwdata[7:0]) && prdata[31:8] == 24'b0)
    else $error("threshold readback mismatch");

endmodule

bind dual_piezo_hit_detector_core dphd_checker u_dphd_checker (.*);

// ----- test/strike_checker.sv -----
`timescale 1ns / 1ps

module strike_checker import dphd_pkg::*; #(
  parameter int SCAN_LEN = 5
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic [SAMPLE_W-1:0] head_sample,
  input  logic [SAMPLE_W-1:0] rim_sample,
  input  logic                ms_tick,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic                zone,
  input  logic [VEL_W-1:0]    velocity,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  input  logic                pready,
  output int                  fault_count,
  output int                  strikes_pending
);

  localparam cfg_t CFG_DEFAULT = '{trigger_level: 8'd20, full_scale_tenths: 8'd80,
                                   mask_ms: 8'd10};

  typedef struct {
    logic             zone;
    logic [VEL_W-1:0] velocity;
  } strike_t;

  cfg_t                settings;
  logic                scanning;
  logic [3:0]          scan_left;
  logic [SAMPLE_W-1:0] head_peak;
  logic [SAMPLE_W-1:0] rim_peak;
  logic [QUIET_W-1:0]  quiet_ms;
  strike_t             awaited_strikes[$];
  int                  faults;

  // peak to velocity, signed span, truncating division, clamped
  function automatic logic [VEL_W-1:0] strike_velocity(input logic [SAMPLE_W-1:0] peak);
    int thr;
    int span;
    int v;
    thr  = int'(settings.trigger_level);
    span = int'(settings.full_scale_tenths) * 10 - thr;
    if (span == 0) return VEL_MAX;
    v = (int'(peak) - thr) * int'(VEL_MAX - VEL_MIN) / span + 1;
    if (v < int'(VEL_MIN)) v = int'(VEL_MIN);
    if (v > int'(VEL_MAX)) v = int'(VEL_MAX);
    return v[VEL_W-1:0];
  endfunction

  task automatic take_sample(input logic [SAMPLE_W-1:0] h, input logic [SAMPLE_W-1:0] r,
                             input logic t);
    strike_t s;
    if (t && quiet_ms != '1) quiet_ms = quiet_ms + 1'b1;
    if (scanning) begin
      if (h > head_peak) head_peak = h;
      if (r > rim_peak) rim_peak = r;
      if (scan_left != 0) scan_left = scan_left - 1'b1;
      if (scan_left == 0) begin
        s.zone     = (rim_peak > head_peak);
        s.velocity = strike_velocity(s.zone ? rim_peak : head_peak);
        awaited_strikes.push_back(s);
        scanning = 1'b0;
        quiet_ms = '0;
      end
    end else if (h > settings.trigger_level) begin
      if (quiet_ms < settings.mask_ms) begin
        quiet_ms = '0;
      end else begin
        scanning  = 1'b1;
        scan_left = (SCAN_LEN == 0) ? 4'd1 : 4'(SCAN_LEN);
        head_peak = '0;
        rim_peak  = '0;
      end
    end
  endtask

  always @(posedge clk) begin : watch
    strike_t want;
    if (rst) begin
      settings  = CFG_DEFAULT;
      scanning  = 1'b0;
      scan_left = '0;
      head_peak = '0;
      rim_peak  = '0;
      quiet_ms  = '0;
      awaited_strikes.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_strikes.size() == 0) begin
          if (faults < 10)
            $display("unexpected strike: zone %0d velocity %0d", zone, velocity);
          faults++;
        end else begin
          want = awaited_strikes.pop_front();
          if (zone !== want.zone || velocity !== want.velocity) begin
            if (faults < 10)
              $display("strike mismatch: expected zone %0d velocity %0d, got zone %0d velocity %0d",
                       want.zone, want.velocity, zone, velocity);
            faults++;
          end
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_TRIGGER_LEVEL:     settings.trigger_level     = pwdata[CFG_W-1:0];
          REG_FULL_SCALE_TENTHS: settings.full_scale_tenths = pwdata[CFG_W-1:0];
          REG_MASK_MS:           settings.mask_ms           = pwdata[CFG_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) take_sample(head_sample, rim_sample, ms_tick);
    end
    fault_count     <= faults;
    strikes_pending <= awaited_strikes.size();
  end

endmodule

// ----- test/tb_dual_piezo_hit_detector_core.sv -----
`timescale 1ns / 1ps

module tb_dual_piezo_hit_detector_core;
  import dphd_pkg::*;

  localparam int SCAN_LEN     = 5;
  localparam int TRIG_RESET   = 20;   // register values after reset
  localparam int MASK_RESET   = 10;
  localparam int DRAIN_CYCLES = 12;   // margin for the back end to finish each strike
  localparam int HOLD_CYCLES  = 300;  // long receiver stall, fills the strike queue
  localparam int ITEM_TARGET  = 1550;
  localparam int TIMEOUT_NS   = 2_000_000;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [SAMPLE_W-1:0] head_sample = '0;
  logic [SAMPLE_W-1:0] rim_sample = '0;
  logic                ms_tick = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                zone;
  logic [VEL_W-1:0]    velocity;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [3:0]          paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  int fault_count;
  int strikes_pending;

  // stimulus-side view of the settings, used only to shape sequences
  int trig_now = TRIG_RESET;
  int mask_now = MASK_RESET;
  int items_sent = 0;

  // idling modes per phase; calm means back-to-back transactions
  bit feed_calm = 1'b0;
  bit drain_calm = 1'b0;
  bit hold_outputs = 1'b0;

  // fixed settings: defaults, zero span with zero mask, negative span, zero span
  // at a nonzero level, all extremes, then a few ordinary and odd spans
  int phase_trig [8] = '{20, 0, 255, 50, 255, 100, 0, 200};
  int phase_fs   [8] = '{80, 0, 0, 5, 255, 25, 102, 15};
  int phase_mask [8] = '{10, 0, 3, 0, 255, 1, 2, 4};

  dual_piezo_hit_detector_core #(.SCAN_SAMPLES(SCAN_LEN)) uut (.*);

  strike_checker #(.SCAN_LEN(SCAN_LEN)) strike_watch (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // hard stop in case the block hangs
  initial begin
    #(TIMEOUT_NS);
    $display("TB_ERROR");
    $finish;
  end

  // one sample transaction: optional gap, then valid held until taken
  task automatic send_sample(input logic [SAMPLE_W-1:0] h, input logic [SAMPLE_W-1:0] r,
                             input logic t);
    int gap;
    gap = feed_calm ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    head_sample <= h;
    rim_sample  <= r;
    ms_tick     <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // apb setup and access phase; psel stays up so writes can run back to back
  task automatic write_reg(input logic [1:0] idx, input int val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'($urandom), val[CFG_W-1:0]};  // upper bits are don't-care
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
  endtask

  task automatic set_config(input int thr, input int fs, input int msk, input logic [2:0] which);
    if (which[0]) write_reg(REG_TRIGGER_LEVEL, thr);
    if (which[1]) write_reg(REG_FULL_SCALE_TENTHS, fs);
    if (which[2]) write_reg(REG_MASK_MS, msk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (which[0]) trig_now = thr;
    if (which[2]) mask_now = msk;
  endtask

  // close any open scan with silent samples, then let every strike drain
  task automatic settle();
    repeat (SCAN_LEN) send_sample('0, '0, 1'b0);
    in_valid <= 1'b0;
    @(posedge clk);
    while (strikes_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // mostly well-formed strikes: quiet lead with enough ticks, strike, scan
  // the rest is noise bursts and strikes that come too early
  task automatic run_phase(input int budget);
    int                  stop;
    int                  choice;
    int                  n;
    int                  amp;
    logic                t;
    logic                tie;
    logic [SAMPLE_W-1:0] h;
    logic [SAMPLE_W-1:0] r;
    stop = items_sent + budget;
    while (items_sent < stop) begin
      choice = $urandom_range(0, 9);
      if (choice == 0) begin
        n = $urandom_range(1, 8);
        repeat (n) send_sample(SAMPLE_W'($urandom), SAMPLE_W'($urandom), 1'($urandom));
      end else begin
        // short lead on a broken sequence, so the strike is likely masked
        n = (choice == 1) ? $urandom_range(0, mask_now) : mask_now + $urandom_range(0, 2);
        while (n > 0) begin
          t = ($urandom_range(0, 3) != 0);
          send_sample(SAMPLE_W'($urandom_range(0, trig_now)), SAMPLE_W'($urandom), t);
          if (t) n--;
        end
        send_sample(SAMPLE_W'($urandom_range(trig_now + 1, 1023)), SAMPLE_W'($urandom),
                    1'($urandom));
        // scan content: random amplitude so velocities spread, sometimes tied peaks
        amp = $urandom_range(0, 1023);
        tie = ($urandom_range(0, 4) == 0);
        repeat (SCAN_LEN) begin
          h = SAMPLE_W'($urandom_range(0, amp));
          r = tie ? h : SAMPLE_W'($urandom_range(0, amp));
          send_sample(h, r, 1'($urandom));
        end
      end
    end
  endtask

  // receiver: a pause per strike, the long hold folded into the same pause
  initial begin : receiver
    int pause;
    while (rst) @(posedge clk);
    forever begin
      pause = drain_calm ? 0 : $urandom_range(0, 15);
      if (hold_outputs) begin
        pause += HOLD_CYCLES;
        hold_outputs = 1'b0;
      end
      if (pause != 0) begin
        out_ready <= 1'b0;
        repeat (pause) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin : stimulus
    int p;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // strike straight after reset is masked by the cleared quiet count
    send_sample(10'd1023, 10'd0, 1'b0);
    // head level equal to the trigger does not count as a strike
    repeat (MASK_RESET) send_sample(10'd20, 10'd1023, 1'b1);
    // strike one above the trigger with the quiet count exactly at the mask
    send_sample(10'd21, 10'd0, 1'b0);
    // tied full-scale peaks give a head hit, tick on the closing sample
    send_sample(10'd1023, 10'd1023, 1'b1);
    send_sample(10'd0, 10'd0, 1'b0);
    send_sample(10'd1023, 10'd1023, 1'b1);
    send_sample(10'd0, 10'd512, 1'b0);
    send_sample(10'd1, 10'd1, 1'b1);
    settle();

    // zero mask: strike accepted right after the previous one, rim wins
    set_config(0, 0, 0, 3'b100);
    send_sample(10'd21, 10'd0, 1'b0);
    send_sample(10'd0, 10'd300, 1'b0);
    send_sample(10'd21, 10'd0, 1'b0);
    send_sample(10'd0, 10'd0, 1'b1);
    send_sample(10'd0, 10'd0, 1'b0);
    send_sample(10'd0, 10'd0, 1'b1);
    settle();

    for (p = 0; p < 8; p++) begin
      set_config(phase_trig[p], phase_fs[p], phase_mask[p], 3'b111);
      feed_calm  = ($urandom_range(0, 3) == 0);
      drain_calm = ($urandom_range(0, 3) == 0);
      run_phase((phase_mask[p] > 100) ? 300 : 120);
      settle();
    end

    // back pressure: sender flat out, receiver stalls long enough to fill the queue
    set_config(30, 40, 0, 3'b111);
    feed_calm    = 1'b1;
    drain_calm   = 1'b0;
    hold_outputs = 1'b1;
    run_phase(100);
    settle();

    // random settings, sometimes only some registers rewritten
    while (items_sent < ITEM_TARGET) begin
      set_config($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 12),
                 3'($urandom_range(1, 7)));
      feed_calm  = ($urandom_range(0, 3) == 0);
      drain_calm = ($urandom_range(0, 3) == 0);
      run_phase(120);
      settle();
    end

    if (fault_count == 0 && strikes_pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/dphd_pkg.sv
design/dphd_front.sv
design/dphd_queue.sv
design/dphd_back.sv
design/dual_piezo_hit_detector_core.sv
design/dphd_checker.sv
test/strike_checker.sv
test/tb_dual_piezo_hit_detector_core.sv
